### rtl/eis_pkg.sv
// shared constants and types for the event interval statistics block
`default_nettype none

package eis_pkg;

  // fixed field widths
  localparam int unsigned SecWidth   = 32;
  localparam int unsigned NsWidth    = 30;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned M2Width    = 64;

  // width of the signed seconds-times-billion product and interval sum
  localparam int unsigned TotalWidth = 36;

  // nanoseconds in one second
  localparam logic signed [TotalWidth-1:0] NsPerSec = 36'sd1000000000;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### rtl/eis_serial_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module eis_serial_div
  import eis_pkg::*;
#(
  parameter int unsigned Width = 46
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [Width-1:0]      dividend_i,
  input  wire logic [CountWidth-1:0] divisor_i,
  output logic                       done_o,
  output logic [Width-1:0]           quotient_o
);

  localparam int unsigned CntWidth = $clog2(Width);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [CountWidth-1:0] rem_q, rem_d;
  logic [CountWidth-1:0] dvs_q, dvs_d;
  logic [Width-1:0]      quo_q, quo_d;
  logic [CountWidth:0]   trial;
  logic                  fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, quo_q[Width-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(Width - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? CountWidth'(trial - {1'b0, dvs_q}) : trial[CountWidth-1:0];
      quo_d = {quo_q[Width-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/eis_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module eis_serial_mul #(
  parameter int unsigned Width = 46
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [Width-1:0]   a_i,
  input  wire logic [Width-1:0]   b_i,
  output logic                    done_o,
  output logic [2*Width-1:0]      product_o
);

  localparam int unsigned CntWidth = $clog2(Width);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [Width-1:0]    a_q, a_d;
  logic [2*Width-1:0]  acc_q, acc_d;
  logic [Width:0]      psum;

  // add the multiplicand into the upper half when the low bit is set
  assign psum = {1'b0, acc_q[2*Width-1:Width]} + (acc_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(Width - 1);
      a_d    = a_i;
      acc_d  = {{Width{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_d = {psum, acc_q[Width-1:1]};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

### rtl/event_interval_statistics_core.sv
// event interval statistics: interval, max, running mean and m2 per timestamp
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | time_seconds_i, time_nanoseconds_i
//   out     | output    | out_valid_o/out_ready_i| reference_only_o ... max_interval_ns_o
//
// a regular event runs from accept through the bit-serial divider for the mean and the
// bit-serial multiplier for m2, then waits in the done state until its result beat is
// loaded into the output register; only then is the next stamp accepted.
// the first event after reset only stores the reference and skips both units.
// rst_ni clears all statistics at once; no clearing pass.
// a finished beat waits in the output register while the next beat is accepted.
`default_nettype none

module event_interval_statistics_core
  import eis_pkg::*;
#(
  parameter int unsigned INTERVAL_BITS      = 30,
  parameter int unsigned MEAN_FRACTION_BITS = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        in_valid_i,
  output logic                                             in_ready_o,
  input  wire logic [SecWidth-1:0]                         time_seconds_i,
  input  wire logic [NsWidth-1:0]                          time_nanoseconds_i,
  output logic                                             out_valid_o,
  input  wire logic                                        out_ready_i,
  output logic                                             reference_only_o,
  output logic [INTERVAL_BITS-1:0]                         interval_ns_o,
  output logic                                             interval_saturated_o,
  output logic [CountWidth-1:0]                            sample_count_o,
  output logic [INTERVAL_BITS+MEAN_FRACTION_BITS-1:0]      mean_ns_q16_o,
  output logic [M2Width-1:0]                               sum_sq_dev_o,
  output logic [INTERVAL_BITS-1:0]                         max_interval_ns_o
);

  localparam int unsigned IB = INTERVAL_BITS;
  localparam int unsigned FB = MEAN_FRACTION_BITS;
  localparam int unsigned MB = IB + FB;
  localparam logic signed [TotalWidth-1:0] IntervalMax =
    TotalWidth'((64'd1 << IB) - 64'd1);

  state_e state_q, state_d;

  // statistics
  logic                  have_ref_q;
  logic [SecWidth-1:0]   prev_s_q;
  logic [NsWidth-1:0]    prev_ns_q;
  logic [CountWidth-1:0] count_q;
  logic [MB-1:0]         mean_q;
  logic [M2Width-1:0]    m2_q;
  logic [IB-1:0]         largest_q;

  // per-event working registers
  logic [SecWidth-1:0]   in_s_q;
  logic [NsWidth-1:0]    in_ns_q;
  logic                  ref_only_q;
  logic [IB-1:0]         interval_q;
  logic                  sat_q;
  logic [MB-1:0]         x_q;
  logic                  neg_q;
  logic [MB-1:0]         mag_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  out_ref_q;
  logic [IB-1:0]         out_ivl_q;
  logic                  out_sat_q;
  logic [CountWidth-1:0] out_count_q;
  logic [MB-1:0]         out_mean_q;
  logic [M2Width-1:0]    out_m2_q;
  logic [IB-1:0]         out_max_q;

  // interval arithmetic
  logic signed [SecWidth:0]     ds;
  logic signed [NsWidth:0]      dn;
  logic signed [TotalWidth-1:0] ds_ext;
  logic signed [TotalWidth-1:0] total;
  logic [IB-1:0]                ivl;
  logic                         ivl_sat;
  logic [CountWidth-1:0]        count_new;
  logic [MB-1:0]                x_new;
  logic [MB:0]                  delta;
  logic [MB-1:0]                delta_mag;

  // welford update
  logic                  div_start, div_done;
  logic [MB-1:0]         quotient;
  logic [MB-1:0]         mean_new;
  logic [MB-1:0]         d2_mag;
  logic                  mul_start, mul_done;
  logic [2*MB-1:0]       product;
  logic [2*IB-1:0]       term;
  logic [M2Width:0]      m2_sum;
  logic                  out_load;

  // interval from the timestamp difference, borrow across seconds
  assign ds     = $signed({1'b0, in_s_q}) - $signed({1'b0, prev_s_q});
  assign dn     = $signed({1'b0, in_ns_q}) - $signed({1'b0, prev_ns_q});
  assign ds_ext = TotalWidth'(signed'(ds[3:0]));
  assign total  = ds_ext * NsPerSec + TotalWidth'(dn);

  always_comb begin
    ivl     = '0;
    ivl_sat = 1'b0;
    priority if (ds < -33'sd1) begin
      ivl = '0;
    end else if (ds > 33'sd7) begin
      ivl     = '1;
      ivl_sat = 1'b1;
    end else if (total < 0) begin
      ivl = '0;
    end else if (total > IntervalMax) begin
      ivl     = '1;
      ivl_sat = 1'b1;
    end else begin
      ivl = total[IB-1:0];
    end
  end

  // count saturates at its maximum
  assign count_new = (count_q == '1) ? count_q : count_q + 1'b1;

  // deviation from the old mean
  assign x_new     = MB'(ivl) << FB;
  assign delta     = {1'b0, x_new} - {1'b0, mean_q};
  assign delta_mag = delta[MB] ? MB'(-delta) : delta[MB-1:0];

  // new mean lies between the old mean and x, so no clamp is needed
  assign mean_new = neg_q ? mean_q - quotient : mean_q + quotient;
  assign d2_mag   = neg_q ? mean_new - x_q : x_q - mean_new;

  // m2 term and saturating accumulate
  assign term   = product[2*MB-1:2*FB];
  assign m2_sum = {1'b0, m2_q} + (M2Width+1)'(term);

  assign div_start = (state_q == S_PREP) && have_ref_q;
  assign mul_start = (state_q == S_DIV) && div_done;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  eis_serial_div #(
    .Width (MB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (delta_mag),
    .divisor_i  (count_new),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  eis_serial_mul #(
    .Width (MB)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mag_q),
    .b_i       (d2_mag),
    .done_o    (mul_done),
    .product_o (product)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: state_d = have_ref_q ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_d = S_MUL;
      S_MUL:  if (mul_done) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      have_ref_q  <= 1'b0;
      prev_s_q    <= '0;
      prev_ns_q   <= '0;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      largest_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_PREP) begin
        have_ref_q <= 1'b1;
        prev_s_q   <= in_s_q;
        prev_ns_q  <= in_ns_q;
        if (have_ref_q) begin
          count_q <= count_new;
          if (ivl > largest_q) largest_q <= ivl;
        end
      end
      if (mul_start) mean_q <= mean_new;
      if ((state_q == S_MUL) && mul_done) begin
        m2_q <= m2_sum[M2Width] ? '1 : m2_sum[M2Width-1:0];
      end
    end
  end

  // per-event payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_s_q  <= time_seconds_i;
      in_ns_q <= time_nanoseconds_i;
    end
    if (state_q == S_PREP) begin
      ref_only_q <= !have_ref_q;
      interval_q <= have_ref_q ? ivl : '0;
      sat_q      <= have_ref_q && ivl_sat;
      x_q        <= x_new;
      neg_q      <= delta[MB];
      mag_q      <= delta_mag;
    end
    if (out_load) begin
      out_ref_q   <= ref_only_q;
      out_ivl_q   <= interval_q;
      out_sat_q   <= sat_q;
      out_count_q <= count_q;
      out_mean_q  <= mean_q;
      out_m2_q    <= m2_q;
      out_max_q   <= largest_q;
    end
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign reference_only_o     = out_ref_q;
  assign interval_ns_o        = out_ivl_q;
  assign interval_saturated_o = out_sat_q;
  assign sample_count_o       = out_count_q;
  assign mean_ns_q16_o        = out_mean_q;
  assign sum_sq_dev_o         = out_m2_q;
  assign max_interval_ns_o    = out_max_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL))
    else $error("multiplier finished outside the multiply phase");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && interval_saturated_o) |-> (interval_ns_o == {IB{1'b1}}))
    else $error("saturated interval is not the maximum");

  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (max_interval_ns_o >= interval_ns_o))
    else $error("largest interval below the reported interval");

  a_ref_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reference_only_o) |-> ((interval_ns_o == '0) && !interval_saturated_o))
    else $error("reference beat carries an interval");
`endif

endmodule

`default_nettype wire

### sim/tb_event_interval_statistics_core.sv
// testbench for the event interval statistics core: directed stamps, then random stamp streams
`timescale 1ns / 100ps

module tb_event_interval_statistics_core
  import eis_pkg::*;
();

  localparam int unsigned IntervalBits = 30;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned MeanBits     = IntervalBits + FracBits;
  localparam longint      IntervalMax  = (64'd1 << IntervalBits) - 1;
  localparam longint      NsPerSecond  = 1000000000;
  localparam int unsigned RandomEvents = 700;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 2 * (2 * MeanBits + 4);
  localparam int unsigned IdleLimit    = 5000;

  // statistics carried by one result beat
  typedef struct packed {
    logic                    reference_only;
    logic [IntervalBits-1:0] interval_ns;
    logic                    interval_saturated;
    logic [CountWidth-1:0]   sample_count;
    logic [MeanBits-1:0]     mean_ns_q16;
    logic [M2Width-1:0]      sum_sq_dev;
    logic [IntervalBits-1:0] max_interval_ns;
  } stats_t;

  // one directed stamp, optionally with its result written out by hand
  typedef struct {
    logic [SecWidth-1:0] sec;
    logic [NsWidth-1:0]  nsec;
    bit                  pinned;
    stats_t              want;
  } stamp_row_t;

  typedef struct {
    bit     pinned;
    stats_t want;
  } pin_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [SecWidth-1:0]     time_seconds_i;
  logic [NsWidth-1:0]      time_nanoseconds_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    reference_only_o;
  logic [IntervalBits-1:0] interval_ns_o;
  logic                    interval_saturated_o;
  logic [CountWidth-1:0]   sample_count_o;
  logic [MeanBits-1:0]     mean_ns_q16_o;
  logic [M2Width-1:0]      sum_sq_dev_o;
  logic [IntervalBits-1:0] max_interval_ns_o;

  // predictor state
  bit                      seen_first     = 1'b0;
  logic [SecWidth-1:0]     last_sec       = '0;
  logic [NsWidth-1:0]      last_nsec      = '0;
  logic [CountWidth-1:0]   interval_total = '0;
  logic [MeanBits-1:0]     mean_q         = '0;
  logic [M2Width-1:0]      m2_q           = '0;
  logic [IntervalBits-1:0] peak_interval  = '0;

  stats_t      expected_stats[$];
  pin_t        pinned_stats[$];
  stamp_row_t  directed_rows[$];
  int unsigned events_accepted  = 0;
  int unsigned results_accepted = 0;
  int unsigned failures         = 0;
  int unsigned idle_cycles      = 0;
  bit          gaps_on          = 1'b1;
  bit          hold_req         = 1'b0;

  event_interval_statistics_core #(
    .INTERVAL_BITS      (IntervalBits),
    .MEAN_FRACTION_BITS (FracBits)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .time_seconds_i       (time_seconds_i),
    .time_nanoseconds_i   (time_nanoseconds_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .reference_only_o     (reference_only_o),
    .interval_ns_o        (interval_ns_o),
    .interval_saturated_o (interval_saturated_o),
    .sample_count_o       (sample_count_o),
    .mean_ns_q16_o        (mean_ns_q16_o),
    .sum_sq_dev_o         (sum_sq_dev_o),
    .max_interval_ns_o    (max_interval_ns_o)
  );

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // interval, peak and welford update for one accepted stamp
  function automatic stats_t advance_statistics(input logic [SecWidth-1:0] sec,
                                                input logic [NsWidth-1:0]  nsec);
    stats_t       r;
    longint       span;
    longint       sample;
    longint       mean_old;
    longint       mean_new;
    longint       dev_old;
    longint       dev_new;
    logic [63:0]  mag_old;
    logic [63:0]  mag_new;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [64:0]  m2_sum;
    r = '0;
    if (!seen_first) begin
      // first stamp only sets the origin
      seen_first       = 1'b1;
      r.reference_only = 1'b1;
    end else begin
      // borrow across seconds, clamp at zero below and at the max above
      span = (longint'(sec) - longint'(last_sec)) * NsPerSecond
           + (longint'(nsec) - longint'(last_nsec));
      if (span < 0) span = 0;
      if (span > IntervalMax) begin
        r.interval_ns        = '1;
        r.interval_saturated = 1'b1;
      end else begin
        r.interval_ns = span[IntervalBits-1:0];
      end
      if (r.interval_ns > peak_interval) peak_interval = r.interval_ns;
      if (interval_total != '1) interval_total++;

      // mean step, signed division truncating toward zero
      sample   = longint'(r.interval_ns) << FracBits;
      mean_old = longint'(mean_q);
      dev_old  = sample - mean_old;
      mean_new = mean_old + dev_old / longint'(interval_total);
      if (mean_new < 0) mean_new = 0;
      mean_q   = mean_new[MeanBits-1:0];
      dev_new  = sample - longint'(mean_q);

      // m2 term from both deviations, scaled down by two fraction widths
      mag_old = (dev_old < 0) ? -dev_old : dev_old;
      mag_new = (dev_new < 0) ? -dev_new : dev_new;
      if ((dev_old < 0) != (dev_new < 0) && dev_old != 0 && dev_new != 0) begin
        term = '0;
      end else begin
        prod = {64'd0, mag_old} * {64'd0, mag_new};
        term = (prod[127:64+2*FracBits] != 0) ? '1 : prod[63+2*FracBits:2*FracBits];
      end
      m2_sum = {1'b0, m2_q} + {1'b0, term};
      m2_q   = m2_sum[64] ? '1 : m2_sum[63:0];
    end
    last_sec          = sec;
    last_nsec         = nsec;
    r.sample_count    = interval_total;
    r.mean_ns_q16     = mean_q;
    r.sum_sq_dev      = m2_q;
    r.max_interval_ns = peak_interval;
    return r;
  endfunction

  function automatic void add_row(input logic [SecWidth-1:0] sec,
                                  input logic [NsWidth-1:0]  nsec,
                                  input bit                  pinned,
                                  input stats_t              want);
    stamp_row_t row;
    row.sec    = sec;
    row.nsec   = nsec;
    row.pinned = pinned;
    row.want   = want;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // offer one stamp beat after a random gap, return once it is taken
  task automatic send_stamp(input logic [SecWidth-1:0] sec, input logic [NsWidth-1:0] nsec,
                            input bit pinned, input stats_t want);
    int unsigned gap;
    int unsigned seen;
    pin_t        pin;
    gap = gaps_on ? $urandom_range(3, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin.pinned = pinned;
    pin.want   = want;
    pinned_stats.push_back(pin);
    seen               = events_accepted;
    in_valid_i         <= 1'b1;
    time_seconds_i     <= sec;
    time_nanoseconds_i <= nsec;
    do @(negedge clk_i); while (events_accepted == seen);
  endtask

  // drop valid and wait until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk_i);
  endtask

  // beat monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin : beat_monitor
    pin_t   pin;
    stats_t got;
    stats_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pin  = pinned_stats.pop_front();
        want = advance_statistics(time_seconds_i, time_nanoseconds_i);
        expected_stats.push_back(pin.pinned ? pin.want : want);
        events_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        got.reference_only     = reference_only_o;
        got.interval_ns        = interval_ns_o;
        got.interval_saturated = interval_saturated_o;
        got.sample_count       = sample_count_o;
        got.mean_ns_q16        = mean_ns_q16_o;
        got.sum_sq_dev         = sum_sq_dev_o;
        got.max_interval_ns    = max_interval_ns_o;
        if (expected_stats.size() == 0) begin
          $error("result beat with no expectation waiting");
          failures++;
        end else begin
          want = expected_stats.pop_front();
          check_field("reference_only", 64'(want.reference_only), 64'(got.reference_only));
          check_field("interval_ns", 64'(want.interval_ns), 64'(got.interval_ns));
          check_field("interval_saturated", 64'(want.interval_saturated),
                      64'(got.interval_saturated));
          check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
          check_field("mean_ns_q16", 64'(want.mean_ns_q16), 64'(got.mean_ns_q16));
          check_field("sum_sq_dev", want.sum_sq_dev, got.sum_sq_dev);
          check_field("max_interval_ns", 64'(want.max_interval_ns),
                      64'(got.max_interval_ns));
        end
        results_accepted++;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    int unsigned seen;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        wait_cycles = HoldCycles;
        hold_req    = 1'b0;
      end else begin
        wait_cycles = gaps_on ? $urandom_range(3, 0) : 0;
      end
      if (wait_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      seen = results_accepted;
      do @(negedge clk_i); while (results_accepted == seen && !hold_req);
    end
  end

  // stamp side: reset, directed table, random streams, end of run
  initial begin : stamp_source
    stats_t              want_first;
    stats_t              want_second;
    logic [SecWidth-1:0] cur_sec;
    longint              cur_nsec;
    int unsigned         pick;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    time_seconds_i     = '0;
    time_nanoseconds_i = '0;

    // first stamp after reset only sets the origin
    want_first                = '0;
    want_first.reference_only = 1'b1;
    // one microsecond later: mean is the sample itself, m2 still zero
    want_second                 = '0;
    want_second.interval_ns     = 30'd1000;
    want_second.sample_count    = 32'd1;
    want_second.mean_ns_q16     = 46'd1000 << FracBits;
    want_second.max_interval_ns = 30'd1000;

    add_row(32'd5, 30'd0, 1'b1, want_first);
    add_row(32'd5, 30'd1000, 1'b1, want_second);
    add_row(32'd6, 30'd0, 1'b0, '0);                        // borrow across seconds
    add_row(32'd5, 30'd0, 1'b0, '0);                        // seconds going back
    add_row(32'd5, 30'd0, 1'b0, '0);                        // same stamp
    add_row(32'd7, 30'd0, 1'b0, '0);                        // too long, saturates
    add_row(32'd7, 30'h3FFF_FFFF, 1'b0, '0);                // ns out of range, exactly max
    add_row(32'd7, 30'd0, 1'b0, '0);                        // ns going back
    add_row(32'd7, 30'd999_999_999, 1'b0, '0);
    add_row(32'd8, 30'd0, 1'b0, '0);                        // one ns
    add_row(32'hFFFF_FFFF, 30'd999_999_999, 1'b0, '0);      // largest stamp
    add_row(32'd0, 30'd0, 1'b0, '0);                        // huge step back
    add_row(32'd0, 30'h3FFF_FFFF, 1'b0, '0);
    add_row(32'd1, 30'd0, 1'b0, '0);                        // borrow goes negative
    add_row(32'd1, 30'h2AAA_AAAA, 1'b0, '0);
    add_row(32'd1, 30'h1555_5555, 1'b0, '0);
    add_row(32'hAAAA_AAAA, 30'd0, 1'b0, '0);
    add_row(32'h5555_5555, 30'd0, 1'b0, '0);
    add_row(32'h5555_5555, 30'd12_345, 1'b0, '0);
    add_row(32'h5555_5556, 30'd73_741_823, 1'b0, '0);       // one second plus, still in range
    add_row(32'h5555_5557, 30'd73_741_824, 1'b0, '0);
    add_row(32'h8000_0000, 30'd0, 1'b0, '0);

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_stamp(directed_rows[i].sec, directed_rows[i].nsec, directed_rows[i].pinned,
                 directed_rows[i].want);
    end
    wait_drained();

    cur_sec  = 32'h8000_0000;
    cur_nsec = 0;
    for (int k = 0; k < RandomEvents; k++) begin
      if (k % 50 == 0) gaps_on = ($urandom_range(3, 0) != 0);
      // long receiver hold while stamps keep coming, then a full drain
      if (k == 150) hold_req = 1'b1;
      if (k == 170 || k == 420) wait_drained();

      if (k >= RandomEvents - 100) begin
        // alternate saturated and zero intervals to push m2 to its ceiling
        if (k % 2 == 0) cur_sec = cur_sec + 2;
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
          // frame-like spacing
          cur_nsec += longint'($urandom_range(40_000_000, 10_000_000));
        end else if (pick < 65) begin
          cur_nsec += longint'($urandom_range(1000, 0));
        end else if (pick < 75) begin
          cur_sec  = cur_sec + $urandom_range(3, 1);
          cur_nsec = longint'($urandom_range(999_999_999, 0));
        end else if (pick < 82) begin
          cur_sec  = cur_sec - $urandom_range(1, 0);
          cur_nsec = longint'($urandom_range(999_999_999, 0));
        end else if (pick < 88) begin
          // repeat the previous stamp
        end else begin
          cur_sec  = $urandom();
          cur_nsec = longint'($urandom_range(30'h3FFF_FFFF, 0));
        end
        if (cur_nsec >= NsPerSecond) begin
          cur_nsec -= NsPerSecond;
          cur_sec  = cur_sec + 1;
        end
      end
      send_stamp(cur_sec, cur_nsec[NsWidth-1:0], 1'b0, '0);
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (failures == 0 && expected_stats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### event_interval_statistics_core.f
rtl/eis_pkg.sv
rtl/eis_serial_div.sv
rtl/eis_serial_mul.sv
rtl/event_interval_statistics_core.sv
sim/tb_event_interval_statistics_core.sv
